>>> sv/alternating_bit_receiver_macros.svh
// Assertion macros used by the alternating bit receiver module.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ALTERNATING_BIT_RECEIVER_MACROS_SVH
`define ALTERNATING_BIT_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/abr_pkg.sv
// Shared constants and types for the alternating bit receiver.
// No dependencies; imported by abr_byte_track and alternating_bit_receiver.
package abr_pkg;

   localparam int MAX_PACKET   = 1024;
   localparam int POS_W        = $clog2(MAX_PACKET + 1);
   localparam int HEADER_BYTES = 4;
   localparam logic [7:0] DIGIT_ZERO = 8'd48;

   typedef logic [POS_W-1:0] abr_pos_type;

   typedef struct packed {
      logic corrupt;
      logic wrong_sequence;
   } abr_verdict_type;

endpackage

>>> sv/abr_byte_track.sv
// Per-packet byte tracker: header capture, sequence byte and signed checksum sum.
// Depends on abr_pkg; yields the packet verdict for the byte being consumed.
module abr_byte_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   input  logic                     expected_bit,
   output abr_pkg::abr_verdict_type verdict
);
   import abr_pkg::*;

   abr_pos_type pos_ff, pos_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] header_ff, header_in;
   logic        hdr_zero_ff, hdr_zero_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  seq_ff, seq_in;

   logic        in_range;
   logic        hz_final;
   logic [31:0] sum_final;
   logic [7:0]  seq_expect;

   always_comb begin
      in_range    = pos_ff < POS_W'(MAX_PACKET);
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      header_in   = header_ff;
      hdr_zero_in = hdr_zero_ff;
      stopped_in  = stopped_ff;
      seq_in      = seq_ff;
      if (in_range) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff < POS_W'(HEADER_BYTES)) begin
            case (pos_ff[1:0])
               2'd0:    header_in[7:0]   = data_byte;
               2'd1:    header_in[15:8]  = data_byte;
               2'd2:    header_in[23:16] = data_byte;
               default: header_in[31:24] = data_byte;
            endcase
            if (data_byte == 8'd0) begin
               hdr_zero_in = 1'b1;
            end
         end else begin
            if (pos_ff == POS_W'(HEADER_BYTES)) begin
               seq_in = data_byte;
            end
            if (!stopped_ff) begin
               // stop summing at the first zero byte
               if (data_byte == 8'd0) begin
                  stopped_in = 1'b1;
               end else begin
                  sum_in = sum_ff + {{24{data_byte[7]}}, data_byte};
               end
            end
         end
      end
   end

   always_comb begin
      hz_final   = hdr_zero_in || (pos_in < POS_W'(HEADER_BYTES));
      sum_final  = hz_final ? 32'd0 : sum_in;
      seq_expect = DIGIT_ZERO + {7'd0, expected_bit};
      verdict.corrupt        = header_in != ~sum_final;
      verdict.wrong_sequence = (pos_in <= POS_W'(HEADER_BYTES)) || (seq_in != seq_expect);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         header_ff   <= '0;
         hdr_zero_ff <= 1'b0;
         stopped_ff  <= 1'b0;
         seq_ff      <= '0;
      end else if (step) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         header_ff   <= header_in;
         hdr_zero_ff <= hdr_zero_in;
         stopped_ff  <= stopped_in;
         seq_ff      <= seq_in;
      end
   end

endmodule

>>> sv/alternating_bit_receiver.sv
// Alternating bit receiver: one packet byte per request, one response per packet.
// A final byte passes the byte stage and then the response register before its response is valid.
// Throughput: one request per cycle while req_stall is low; the byte stage and response register set it.
// A final byte waits in the byte stage only while an earlier response is stalled.
// Synchronous active-high reset clears packet state, expected bit and first-packet flag.
// Depends on abr_pkg, abr_byte_track and alternating_bit_receiver_macros.svh.
`include "alternating_bit_receiver_macros.svh"

module alternating_bit_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_deliver,
   output logic       rsp_ack_bit,
   output logic       rsp_corrupt,
   output logic       rsp_wrong_sequence
);
   import abr_pkg::*;

   logic            s1_valid_ff;
   logic [7:0]      s1_byte_ff;
   logic            s1_last_ff;
   logic            s1_go;
   logic            req_take;
   logic            rsp_take;
   logic            finish;

   logic            expected_bit_ff, expected_bit_in;
   logic            once_ff, once_in;
   logic            out_valid_ff;
   logic            deliver_in;
   abr_verdict_type verdict;

   abr_byte_track u_track (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .data_byte    (s1_byte_ff),
      .last_byte    (s1_last_ff),
      .expected_bit (expected_bit_ff),
      .verdict      (verdict)
   );

   // a final byte needs room in the response register; other bytes always advance
   assign s1_go     = s1_valid_ff && (!s1_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign finish    = s1_go && s1_last_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      deliver_in      = !((verdict.corrupt || verdict.wrong_sequence) && once_ff);
      expected_bit_in = expected_bit_ff;
      once_in         = once_ff;
      if (finish && deliver_in) begin
         expected_bit_in = ~expected_bit_ff;
         once_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         expected_bit_ff <= 1'b0;
         once_ff         <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
         expected_bit_ff <= expected_bit_in;
         once_ff         <= once_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (finish) begin
         rsp_deliver        <= deliver_in;
         // acknowledge the expected bit on delivery, the previous one otherwise
         rsp_ack_bit        <= deliver_in ? expected_bit_ff : ~expected_bit_ff;
         rsp_corrupt        <= verdict.corrupt;
         rsp_wrong_sequence <= verdict.wrong_sequence;
      end
   end

   `ABR_ASSERT_NXT(a_final_loads_rsp, finish, rsp_valid, "final byte did not load a response")
   `ABR_ASSERT_IMP(a_drop_has_cause, rsp_valid && !rsp_deliver,
      rsp_corrupt || rsp_wrong_sequence, "packet dropped without a fault flag")
   `ABR_ASSERT_IMP(a_ack_is_previous, rsp_valid, rsp_ack_bit != expected_bit_ff,
      "ack bit does not match the toggled expected bit")
   `ABR_ASSERT_NXT(a_bit_moves_on_finish, !finish, $stable(expected_bit_ff),
      "expected bit changed without a packet end")

endmodule

>>> dv/alternating_bit_receiver_test.sv
// Self-checking testbench for alternating_bit_receiver: drives packet bytes, predicts
// each packet's acknowledgement and compares it with the block's response.
// Depends on abr_pkg and the alternating_bit_receiver RTL.
`timescale 1ns / 1ps

module alternating_bit_receiver_test;
   import abr_pkg::*;

   typedef struct packed {
      logic deliver;
      logic ack_bit;
      logic corrupt;
      logic wrong_sequence;
   } ack_verdict_type;

   typedef struct packed {
      logic [7:0]      data;
      logic            last;
      logic            typed;
      ack_verdict_type ack;
   } script_row_type;

   typedef logic [7:0] packet_q_type [$];

   localparam int ITEM_TARGET = 1850;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 4000;

   localparam ack_verdict_type NO_ACK      = '0;
   localparam ack_verdict_type SHORT_FIRST = '{deliver: 1'b1, ack_bit: 1'b0, corrupt: 1'b1,
                                               wrong_sequence: 1'b1};
   localparam ack_verdict_type SHORT_LATER = '{deliver: 1'b0, ack_bit: 1'b0, corrupt: 1'b1,
                                               wrong_sequence: 1'b1};
   localparam ack_verdict_type CLEAN_ONE   = '{deliver: 1'b1, ack_bit: 1'b1, corrupt: 1'b0,
                                               wrong_sequence: 1'b0};
   localparam ack_verdict_type REPEAT_ONE  = '{deliver: 1'b0, ack_bit: 1'b1, corrupt: 1'b0,
                                               wrong_sequence: 1'b1};

   // short packets, a clean '1' packet and its duplicate, a packet whose sum
   // stops at a zero byte with signed bytes, and a header holding a zero byte
   localparam script_row_type OPENING_SCRIPT [26] = '{
      '{8'h00, 1'b1, 1'b1, SHORT_FIRST},
      '{8'hFF, 1'b1, 1'b1, SHORT_LATER},
      '{8'hCE, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'h31, 1'b1, 1'b1, CLEAN_ONE},
      '{8'hCE, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'h31, 1'b1, 1'b1, REPEAT_ONE},
      '{8'hD0, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'h30, 1'b0, 1'b0, NO_ACK},
      '{8'h7F, 1'b0, 1'b0, NO_ACK},
      '{8'h80, 1'b0, 1'b0, NO_ACK},
      '{8'h00, 1'b0, 1'b0, NO_ACK},
      '{8'h55, 1'b1, 1'b0, NO_ACK},
      '{8'h00, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'hFF, 1'b0, 1'b0, NO_ACK},
      '{8'h31, 1'b1, 1'b0, NO_ACK}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_deliver;
   logic       rsp_ack_bit;
   logic       rsp_corrupt;
   logic       rsp_wrong_sequence;

   alternating_bit_receiver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_deliver        (rsp_deliver),
      .rsp_ack_bit        (rsp_ack_bit),
      .rsp_corrupt        (rsp_corrupt),
      .rsp_wrong_sequence (rsp_wrong_sequence)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // packet tracker state
   int unsigned  pkt_pos = 0;
   logic [31:0]  pkt_sum = '0;
   logic [31:0]  hdr_word = '0;
   logic [7:0]   seq_byte = '0;
   bit           hdr_zero = 1'b0;
   bit           sum_halt = 1'b0;
   bit           seq_seen = 1'b0;
   bit           want_bit = 1'b0;
   bit           first_done = 1'b0;

   ack_verdict_type pending_acks [$];
   int              items_sent = 0;
   int              acks_seen = 0;
   int              fault_count = 0;
   bit              lean_sender = 1'b0;
   bit              lean_receiver = 1'b0;
   bit              hold_off_due = 1'b0;

   task automatic track_packet_byte(input logic [7:0] b, input logic last,
                                    output bit has_ack, output ack_verdict_type ack);
      logic [31:0] chk;
      ack = NO_ACK;
      if (pkt_pos < MAX_PACKET) begin
         if (pkt_pos < HEADER_BYTES) begin
            hdr_word |= 32'(b) << (8 * pkt_pos);
            if (b == 8'h00) hdr_zero = 1'b1;
         end else begin
            if (pkt_pos == HEADER_BYTES) begin
               seq_byte = b;
               seq_seen = 1'b1;
            end
            if (!sum_halt) begin
               if (b == 8'h00) sum_halt = 1'b1;
               else pkt_sum += {{24{b[7]}}, b};
            end
         end
         pkt_pos++;
      end
      has_ack = last;
      if (last) begin
         // a zero or missing header byte forces the sum to zero
         chk = (hdr_zero || pkt_pos < HEADER_BYTES) ? 32'h0 : pkt_sum;
         ack.corrupt = (hdr_word != ~chk);
         ack.wrong_sequence = !seq_seen || (seq_byte != 8'(DIGIT_ZERO + 8'(want_bit)));
         if ((ack.corrupt || ack.wrong_sequence) && first_done) begin
            ack.deliver = 1'b0;
            ack.ack_bit = ~want_bit;
         end else begin
            ack.deliver = 1'b1;
            ack.ack_bit = want_bit;
            first_done = 1'b1;
            want_bit = ~want_bit;
         end
         pkt_pos = 0;
         pkt_sum = '0;
         hdr_word = '0;
         seq_byte = '0;
         hdr_zero = 1'b0;
         sum_halt = 1'b0;
         seq_seen = 1'b0;
      end
   endtask

   function automatic logic [31:0] body_checksum(input packet_q_type pkt);
      logic [31:0] acc;
      acc = '0;
      for (int i = HEADER_BYTES; i < pkt.size() && i < MAX_PACKET; i++) begin
         if (pkt[i] == 8'h00) break;
         acc += {{24{pkt[i][7]}}, pkt[i]};
      end
      return acc;
   endfunction

   // mostly well-formed packets; the rest duplicates, damaged, short or noise
   task automatic make_packet(input bit go_long, output packet_q_type pkt);
      int          kind;
      int          body_len;
      int          flip_at;
      logic [31:0] hdr;
      logic [7:0]  b;
      pkt = {};
      kind = go_long ? 0 : $urandom_range(0, 99);
      if (kind >= 75) begin
         body_len = (kind >= 85) ? $urandom_range(1, 24) : $urandom_range(1, 4);
         repeat (body_len) pkt.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat (HEADER_BYTES) pkt.push_back(8'h00);
      pkt.push_back(8'(DIGIT_ZERO + 8'((kind >= 55 && kind < 65) ? ~want_bit : want_bit)));
      body_len = go_long ? MAX_PACKET - HEADER_BYTES - 1 + $urandom_range(1, 6)
                         : $urandom_range(0, 8);
      repeat (body_len) begin
         b = ($urandom_range(0, 7) == 0 && !go_long) ? 8'h00 : 8'($urandom_range(1, 255));
         pkt.push_back(b);
      end
      hdr = ~body_checksum(pkt);
      for (int k = 0; k < HEADER_BYTES; k++) pkt[k] = hdr[8*k +: 8];
      if (kind >= 65) begin
         flip_at = $urandom_range(0, pkt.size() - 1);
         pkt[flip_at][$urandom_range(0, 7)] ^= 1'b1;
      end
   endtask

   // enter at a falling edge, leave at the falling edge after the request is taken
   task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                            input ack_verdict_type typed_ack);
      int              gap;
      bit              has_ack;
      ack_verdict_type ack;
      gap = lean_sender ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      track_packet_byte(b, last, has_ack, ack);
      if (has_ack) pending_acks.push_back(typed ? typed_ack : ack);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic got, input logic want);
      $display("ERROR: ack %0d field %s got %b, want %b", acks_seen, field, got, want);
      fault_count++;
   endtask

   task automatic check_ack();
      ack_verdict_type want;
      if (pending_acks.size() == 0) begin
         report_mismatch("valid", 1'b1, 1'b0);
      end else begin
         want = pending_acks.pop_front();
         if (rsp_deliver !== want.deliver)
            report_mismatch("deliver", rsp_deliver, want.deliver);
         if (rsp_ack_bit !== want.ack_bit)
            report_mismatch("ack_bit", rsp_ack_bit, want.ack_bit);
         if (rsp_corrupt !== want.corrupt)
            report_mismatch("corrupt", rsp_corrupt, want.corrupt);
         if (rsp_wrong_sequence !== want.wrong_sequence)
            report_mismatch("wrong_sequence", rsp_wrong_sequence, want.wrong_sequence);
      end
      acks_seen++;
   endtask

   initial begin : response_side
      int hold;
      @(negedge clock);
      forever begin
         hold = lean_receiver ? 0 : $urandom_range(0, 15);
         if (hold_off_due) begin
            hold = HOLD_CYCLES;
            hold_off_due = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !reset));
         check_ack();
         if ($urandom_range(0, 7) == 0) lean_receiver = !lean_receiver;
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("alternating_bit_receiver: mismatch");
            $finish;
         end
      end
   end

   initial begin : request_side
      packet_q_type pkt;
      bit           held;
      bit           paused;
      bit           long_done;
      bit           go_long;
      held = 1'b0;
      paused = 1'b0;
      long_done = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      lean_sender = 1'b0;
      foreach (OPENING_SCRIPT[i])
         send_byte(OPENING_SCRIPT[i].data, OPENING_SCRIPT[i].last,
                   OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].ack);

      while (items_sent < ITEM_TARGET) begin
         // stall the response side long enough to back up the request side
         if (!held && items_sent >= 400) begin
            hold_off_due = 1'b1;
            held = 1'b1;
         end
         if (!paused && items_sent >= 1100) begin
            paused = 1'b1;
            // drop the request while draining so the last byte is not taken again
            req_valid <= 1'b0;
            do @(negedge clock); while (pending_acks.size() != 0);
         end
         go_long = !long_done && items_sent >= 700;
         if (go_long) long_done = 1'b1;
         make_packet(go_long, pkt);
         lean_sender = ($urandom_range(0, 3) == 0);
         foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, NO_ACK);
      end
      req_valid <= 1'b0;

      while (pending_acks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0 && pending_acks.size() == 0) begin
         $display("alternating_bit_receiver: match");
      end else begin
         $display("alternating_bit_receiver: mismatch");
      end
      $finish;
   end

endmodule
